// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the bit field packer.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MBFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mbfp check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low
`define MBFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mbfp check failed: next-cycle implication");

`endif

// ----- rtl/mbfp_pkg.sv -----
// Package for the MSB-first bit field packer: widths, operation codes,
// command kinds and the command record passed from front to back. No dependencies.
package mbfp_pkg;

    // Fixed field widths
    localparam int PAYLOAD_W  = 64;
    localparam int FIELD_W    = 32;
    localparam int WIDTH_W    = 6;
    localparam int CURSOR_W   = 7;
    localparam int OP_W       = 3;
    localparam int LEN_W      = 4;

    // Largest field in bits, and the default frame size
    localparam logic [WIDTH_W-1:0] FIELD_MAX = 6'd32;
    localparam int FRAME_BITS_DEF = 64;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input channel
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_REWIND = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

    // Decoded command kinds
    typedef enum logic [2:0] {
        CMD_NOP    = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_REWIND = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_LOAD   = 3'd5
    } cmd_kind_t;

    // Classified command: width already capped at FIELD_MAX
    typedef struct packed {
        cmd_kind_t              kind;
        logic [WIDTH_W-1:0]     width;
        logic [FIELD_W-1:0]     value;
        logic [PAYLOAD_W-1:0]   payload;
    } cmd_t;

endpackage

// ----- rtl/mbfp_front.sv -----
// Front end of the bit field packer: takes input beats, decodes the operation
// and caps the field width. Depends on mbfp_pkg; feeds mbfp_cmd_queue.
module mbfp_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mbfp_pkg::OP_W-1:0]         s_operation,
    input  logic [mbfp_pkg::FIELD_W-1:0]      s_field_value,
    input  logic [mbfp_pkg::WIDTH_W-1:0]      s_field_width,
    input  logic [mbfp_pkg::PAYLOAD_W-1:0]    s_payload_in,
    output logic                              push_valid,
    output mbfp_pkg::cmd_t                    push_cmd,
    input  logic                              push_ready
);

    mbfp_pkg::cmd_kind_t         kind;
    logic [mbfp_pkg::WIDTH_W-1:0] width_cap;

    // Operation decode; undefined codes become a no-op
    always_comb begin
        unique case (s_operation)
            mbfp_pkg::OP_CLEAR:  kind = mbfp_pkg::CMD_CLEAR;
            mbfp_pkg::OP_REWIND: kind = mbfp_pkg::CMD_REWIND;
            mbfp_pkg::OP_WRITE:  kind = mbfp_pkg::CMD_WRITE;
            mbfp_pkg::OP_READ:   kind = mbfp_pkg::CMD_READ;
            mbfp_pkg::OP_LOAD:   kind = mbfp_pkg::CMD_LOAD;
            default:             kind = mbfp_pkg::CMD_NOP;
        endcase
    end

    // Widths above the field limit act as the limit
    assign width_cap = (s_field_width > mbfp_pkg::FIELD_MAX) ? mbfp_pkg::FIELD_MAX
                                                             : s_field_width;

    assign push_cmd.kind    = kind;
    assign push_cmd.width   = width_cap;
    assign push_cmd.value   = s_field_value;
    assign push_cmd.payload = s_payload_in;

    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

// ----- rtl/mbfp_cmd_queue.sv -----
// Short command queue between front and back of the bit field packer.
// Depends on mbfp_pkg for the command record and the depth.
module mbfp_cmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    input  mbfp_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    output logic            pop_valid,
    output mbfp_pkg::cmd_t  pop_cmd,
    input  logic            pop_ready
);

    localparam logic [mbfp_pkg::QPTR_W-1:0] PTR_LAST =
        mbfp_pkg::QPTR_W'(mbfp_pkg::QUEUE_DEPTH - 1);
    localparam logic [mbfp_pkg::QCNT_W-1:0] CNT_FULL =
        mbfp_pkg::QCNT_W'(mbfp_pkg::QUEUE_DEPTH);

    mbfp_pkg::cmd_t                 entry_reg [mbfp_pkg::QUEUE_DEPTH];
    logic [mbfp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mbfp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mbfp_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/mbfp_back.sv -----
// Back end of the bit field packer (needs mbfp_pkg): holds payload, cursor and
// limit, carries out one command per cycle into a result register unless held.
module mbfp_back #(
    parameter int FRAME_BITS = mbfp_pkg::FRAME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mbfp_pkg::CURSOR_W-1:0]     cfg_wdata,
    input  logic                              cmd_valid,
    input  mbfp_pkg::cmd_t                    cmd,
    output logic                              cmd_ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbfp_pkg::FIELD_W-1:0]      m_read_value,
    output logic [mbfp_pkg::CURSOR_W-1:0]     m_cursor_bits,
    output logic [mbfp_pkg::CURSOR_W-1:0]     m_free_bits,
    output logic [mbfp_pkg::LEN_W-1:0]        m_length_bytes,
    output logic [mbfp_pkg::PAYLOAD_W-1:0]    m_payload_out,
    output logic                              m_overflow
);

    localparam int PW = mbfp_pkg::PAYLOAD_W;
    localparam int FW = mbfp_pkg::FIELD_W;
    localparam int CW = mbfp_pkg::CURSOR_W;
    localparam int WW = mbfp_pkg::WIDTH_W;

    localparam logic [CW-1:0] FRAME_LIM = CW'(FRAME_BITS);
    // Bits at frame positions FRAME_BITS and above are kept clear on load
    localparam logic [PW-1:0] KEEP_MASK = ~({PW{1'b1}} >> FRAME_BITS);
    localparam logic [WW-1:0] FIELD_FULL = WW'(FW);

    logic [CW-1:0]      limit_reg;
    logic [PW-1:0]      payload_reg, payload_next;
    logic [CW-1:0]      cursor_reg, cursor_next;

    logic               do_exec;
    logic [CW-1:0]      avail;
    logic               short_fit;
    logic [WW-1:0]      nbits;
    logic [FW-1:0]      top_mask;
    logic [FW-1:0]      wr_bits;
    logic [PW+FW-1:0]   wr_place;
    logic [PW-1:0]      rd_window;
    logic [FW-1:0]      rd_bits;
    logic [FW-1:0]      read_next;
    logic               ovf_next;
    logic [CW-1:0]      free_next;
    logic [mbfp_pkg::LEN_W-1:0] len_next;

    // Back end advances whenever the result register is free or being drained
    assign cmd_ready = !m_valid || m_ready;
    assign do_exec   = cmd_valid && cmd_ready;

    // Limit register: max_bits capped at the frame size
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= FRAME_LIM;
        end else if (cfg_we) begin
            limit_reg <= (cfg_wdata > FRAME_LIM) ? FRAME_LIM : cfg_wdata;
        end
    end

    // Room left before the limit and bits actually moved
    assign avail     = (limit_reg > cursor_reg) ? (limit_reg - cursor_reg) : '0;
    assign short_fit = ({1'b0, cmd.width} > avail);
    assign nbits     = short_fit ? avail[WW-1:0] : cmd.width;
    assign top_mask  = ~({FW{1'b1}} >> nbits);

    // Write path: left-justify the field, keep the leading nbits, place at cursor
    assign wr_bits  = (cmd.value << (FIELD_FULL - cmd.width)) & top_mask;
    assign wr_place = {wr_bits, {PW{1'b0}}} >> cursor_reg;

    // Read path: window at cursor, keep nbits, right-justify over the full width
    assign rd_window = payload_reg << cursor_reg;
    assign rd_bits   = rd_window[PW-1 -: FW] & top_mask;

    // Command execution
    always_comb begin
        payload_next = payload_reg;
        cursor_next  = cursor_reg;
        read_next    = '0;
        ovf_next     = 1'b0;
        case (cmd.kind)
            mbfp_pkg::CMD_CLEAR: begin
                payload_next = '0;
                cursor_next  = '0;
            end
            mbfp_pkg::CMD_REWIND: begin
                cursor_next = '0;
            end
            mbfp_pkg::CMD_WRITE: begin
                payload_next = payload_reg | wr_place[PW+FW-1 -: PW];
                cursor_next  = cursor_reg + {1'b0, nbits};
                ovf_next     = short_fit;
            end
            mbfp_pkg::CMD_READ: begin
                read_next   = rd_bits >> (FIELD_FULL - cmd.width);
                cursor_next = short_fit ? limit_reg : cursor_reg + {1'b0, nbits};
                ovf_next    = short_fit;
            end
            mbfp_pkg::CMD_LOAD: begin
                payload_next = cmd.payload & KEEP_MASK;
            end
            default: begin
                payload_next = payload_reg;
            end
        endcase
    end

    // Status derived from the new cursor
    assign free_next = (limit_reg > cursor_next) ? (limit_reg - cursor_next) : '0;
    assign len_next  = cursor_next[CW-1] ? mbfp_pkg::LEN_W'(8)
                                         : {1'b0, cursor_next[5:3]} + 1'b1;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_reg <= '0;
            cursor_reg  <= '0;
        end else if (do_exec) begin
            payload_reg <= payload_next;
            cursor_reg  <= cursor_next;
        end
    end

    // Result beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (do_exec) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    // Result beat payload
    always_ff @(posedge aclk) begin
        if (do_exec) begin
            m_read_value   <= read_next;
            m_cursor_bits  <= cursor_next;
            m_free_bits    <= free_next;
            m_length_bytes <= len_next;
            m_payload_out  <= payload_next;
            m_overflow     <= ovf_next;
        end
    end

endmodule

// ----- rtl/msb_first_bit_field_packer_unit.sv -----
// Top level of the MSB-first bit field packer: front decode, command queue,
// back end. Depends on mbfp_pkg, mbfp_front, mbfp_cmd_queue and mbfp_back.
//
//  Channel   Direction  Handshake            Beat contents
//  s_*       in         s_valid / s_ready    operation, field value, width, payload
//  m_*       out        m_valid / m_ready    read value, cursor, free, length, payload, overflow
//  cfg_*     in         cfg_we (no wait)     max_bits
//
// One beat per cycle sustained while m_ready stays high; an accepted input beat is
// written into the queue, then executed by the back end into the result register.
// The back end's combinational shift-and-mask over the 64-bit payload sets the rate.
// Synchronous active-low reset clears payload, cursor, queue and sets max_bits to
// FRAME_BITS (default 64). A stalled m_ready holds the result; the two-entry queue
// takes two more beats, then s_ready stays low until the result beat drains.
module msb_first_bit_field_packer_unit #(
    parameter int FRAME_BITS = mbfp_pkg::FRAME_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mbfp_pkg::CURSOR_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mbfp_pkg::OP_W-1:0]         s_operation,
    input  logic [mbfp_pkg::FIELD_W-1:0]      s_field_value,
    input  logic [mbfp_pkg::WIDTH_W-1:0]      s_field_width,
    input  logic [mbfp_pkg::PAYLOAD_W-1:0]    s_payload_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbfp_pkg::FIELD_W-1:0]      m_read_value,
    output logic [mbfp_pkg::CURSOR_W-1:0]     m_cursor_bits,
    output logic [mbfp_pkg::CURSOR_W-1:0]     m_free_bits,
    output logic [mbfp_pkg::LEN_W-1:0]        m_length_bytes,
    output logic [mbfp_pkg::PAYLOAD_W-1:0]    m_payload_out,
    output logic                              m_overflow
);

    logic            push_valid, push_ready;
    mbfp_pkg::cmd_t  push_cmd;
    logic            pop_valid, pop_ready;
    mbfp_pkg::cmd_t  pop_cmd;

    // Decode and width capping
    mbfp_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_field_value (s_field_value),
        .s_field_width (s_field_width),
        .s_payload_in  (s_payload_in),
        .push_valid    (push_valid),
        .push_cmd      (push_cmd),
        .push_ready    (push_ready)
    );

    // Decoupling queue
    mbfp_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    // Execution and result register
    mbfp_back #(
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd_valid      (pop_valid),
        .cmd            (pop_cmd),
        .cmd_ready      (pop_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_cursor_bits  (m_cursor_bits),
        .m_free_bits    (m_free_bits),
        .m_length_bytes (m_length_bytes),
        .m_payload_out  (m_payload_out),
        .m_overflow     (m_overflow)
    );

endmodule

// ----- rtl/mbfp_checker.sv -----
// Port-level checks for the bit field packer top level, bound in below.
// Depends on mbfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbfp_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [mbfp_pkg::FIELD_W-1:0]      m_read_value,
    input  logic [mbfp_pkg::CURSOR_W-1:0]     m_cursor_bits,
    input  logic [mbfp_pkg::CURSOR_W-1:0]     m_free_bits,
    input  logic [mbfp_pkg::LEN_W-1:0]        m_length_bytes,
    input  logic [mbfp_pkg::PAYLOAD_W-1:0]    m_payload_out,
    input  logic                              m_overflow
);

    logic [mbfp_pkg::CURSOR_W:0] used_plus_free;
    logic [mbfp_pkg::LEN_W-1:0]  len_expect;

    assign used_plus_free = {1'b0, m_cursor_bits} + {1'b0, m_free_bits};
    assign len_expect     = m_cursor_bits[mbfp_pkg::CURSOR_W-1] ? mbfp_pkg::LEN_W'(8)
                          : {1'b0, m_cursor_bits[5:3]} + 1'b1;

    // A held result beat keeps its payload, read value and cursor
    `MBFP_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_payload_out) && $stable(m_read_value) && $stable(m_cursor_bits))

    // Overflow always leaves the cursor at or past the limit
    `MBFP_ASSERT_NOW(a_ovf_no_room, m_valid && m_overflow, m_free_bits == '0)

    // While room is left, cursor plus room never exceeds a full 64-bit frame
    `MBFP_ASSERT_NOW(a_room_in_frame, m_valid && (m_free_bits != '0), used_plus_free <= 8'd64)

    // Length in bytes tracks the cursor
    `MBFP_ASSERT_NOW(a_len_tracks, m_valid, m_length_bytes == len_expect)

endmodule

bind msb_first_bit_field_packer_unit mbfp_checker u_mbfp_checker (.*);

// ----- tb/mbfp_field_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the MSB-first bit field packer: keeps its own payload, cursor
// and max_bits from the beats it sees, and compares every result beat. Needs mbfp_pkg.
module mbfp_field_checker
    import mbfp_pkg::*;
#(
    parameter int FRAME_BITS = mbfp_pkg::FRAME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CURSOR_W-1:0]    cfg_wdata,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [FIELD_W-1:0]     s_field_value,
    input  logic [WIDTH_W-1:0]     s_field_width,
    input  logic [PAYLOAD_W-1:0]   s_payload_in,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [FIELD_W-1:0]     m_read_value,
    input  logic [CURSOR_W-1:0]    m_cursor_bits,
    input  logic [CURSOR_W-1:0]    m_free_bits,
    input  logic [LEN_W-1:0]       m_length_bytes,
    input  logic [PAYLOAD_W-1:0]   m_payload_out,
    input  logic                   m_overflow,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic [FIELD_W-1:0]   read_value;
        logic [CURSOR_W-1:0]  cursor_bits;
        logic [CURSOR_W-1:0]  free_bits;
        logic [LEN_W-1:0]     length_bytes;
        logic [PAYLOAD_W-1:0] payload_out;
        logic                 overflow;
    } field_result_t;

    // Shadow state: byte 0 sits in bits 63..56, so bit position p is bit 63-p
    logic [PAYLOAD_W-1:0] frame_bytes;
    logic [CURSOR_W-1:0]  cursor;
    logic [CURSOR_W-1:0]  max_bits_reg;

    field_result_t expected_results[$];

    // Apply one operation to the shadow state and work out the result beat
    function automatic field_result_t apply_field_op(
        input logic [OP_W-1:0]      op,
        input logic [FIELD_W-1:0]   val,
        input logic [WIDTH_W-1:0]   width_in,
        input logic [PAYLOAD_W-1:0] pin
    );
        field_result_t        r;
        int unsigned          lim;
        int unsigned          w;
        int unsigned          cur;
        int unsigned          len;
        int unsigned          i;
        logic [FIELD_W-1:0]   rd;
        logic [PAYLOAD_W-1:0] keep;
        logic                 ovf;
        logic                 b;

        lim = (max_bits_reg > FRAME_BITS) ? FRAME_BITS : max_bits_reg;
        w   = (width_in > FIELD_MAX) ? FIELD_MAX : width_in;
        cur = cursor;
        rd  = '0;
        ovf = 1'b0;

        case (op)
            OP_CLEAR: begin
                frame_bytes = '0;
                cur = 0;
            end
            OP_REWIND: begin
                cur = 0;
            end
            OP_WRITE: begin
                // bits past the limit are dropped; cursor never moves past it
                for (i = 0; i < w; i++) begin
                    b = val[w - 1 - i];
                    if (cur < lim) begin
                        if (b)
                            frame_bytes[PAYLOAD_W - 1 - cur] = 1'b1;
                        cur++;
                    end else begin
                        ovf = 1'b1;
                    end
                end
            end
            OP_READ: begin
                // bits past the limit read as zero and pin the cursor to it
                for (i = 0; i < w; i++) begin
                    b = 1'b0;
                    if (cur < lim) begin
                        b = frame_bytes[PAYLOAD_W - 1 - cur];
                        cur++;
                    end else begin
                        ovf = 1'b1;
                    end
                    rd = {rd[FIELD_W-2:0], b};
                end
                if (ovf)
                    cur = lim;
            end
            OP_LOAD: begin
                // positions at and above the frame size are stored as zero
                keep = (FRAME_BITS >= PAYLOAD_W) ? '1 : ~({PAYLOAD_W{1'b1}} >> FRAME_BITS);
                frame_bytes = pin & keep;
            end
            default: begin
            end
        endcase

        cursor = cur[CURSOR_W-1:0];
        len = cur / 8 + 1;
        if (len > 8)
            len = 8;

        r.read_value   = rd;
        r.cursor_bits  = cur[CURSOR_W-1:0];
        r.free_bits    = (lim > cur) ? CURSOR_W'(lim - cur) : '0;
        r.length_bytes = len[LEN_W-1:0];
        r.payload_out  = frame_bytes;
        r.overflow     = ovf;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (seen !== want) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        end
    endtask

    // Watch both channels and the register port on every edge
    always @(posedge aclk) begin : watch_beats
        field_result_t want;
        if (!aresetn) begin
            frame_bytes  = '0;
            cursor       = '0;
            max_bits_reg = CURSOR_W'(64);
            mismatches   = 0;
            expected_results.delete();
        end else begin
            // result side first: its expectation was queued on an earlier edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing expected, expected none, actual %0h",
                             $time, m_payload_out);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("read_value", want.read_value, m_read_value);
                    compare_field("cursor_bits", want.cursor_bits, m_cursor_bits);
                    compare_field("free_bits", want.free_bits, m_free_bits);
                    compare_field("length_bytes", want.length_bytes, m_length_bytes);
                    compare_field("payload_out", want.payload_out, m_payload_out);
                    compare_field("overflow", want.overflow, m_overflow);
                end
            end
            if (cfg_we)
                max_bits_reg = cfg_wdata;
            if (s_valid && s_ready)
                expected_results.push_back(apply_field_op(s_operation, s_field_value,
                                                          s_field_width, s_payload_in));
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the bit field packer testbench: clock, reset, stimulus and verdict.
// Depends on mbfp_pkg, msb_first_bit_field_packer_unit and mbfp_field_checker.
module testbench;
    import mbfp_pkg::*;

    localparam int FRAME = mbfp_pkg::FRAME_BITS_DEF;
    localparam logic [OP_W-1:0] OP_LAST = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CURSOR_W-1:0]  cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation;
    logic [FIELD_W-1:0]   s_field_value;
    logic [WIDTH_W-1:0]   s_field_width;
    logic [PAYLOAD_W-1:0] s_payload_in;
    logic                 m_valid;
    logic                 m_ready;
    logic [FIELD_W-1:0]   m_read_value;
    logic [CURSOR_W-1:0]  m_cursor_bits;
    logic [CURSOR_W-1:0]  m_free_bits;
    logic [LEN_W-1:0]     m_length_bytes;
    logic [PAYLOAD_W-1:0] m_payload_out;
    logic                 m_overflow;

    int mismatch_count;
    int results_pending;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;
    int beats_sent      = 0;
    int limit_writes    = 0;
    int op_count[8];

    msb_first_bit_field_packer_unit #(.FRAME_BITS(FRAME)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_field_value  (s_field_value),
        .s_field_width  (s_field_width),
        .s_payload_in   (s_payload_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_cursor_bits  (m_cursor_bits),
        .m_free_bits    (m_free_bits),
        .m_length_bytes (m_length_bytes),
        .m_payload_out  (m_payload_out),
        .m_overflow     (m_overflow)
    );

    mbfp_field_checker #(.FRAME_BITS(FRAME)) u_field_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_field_value  (s_field_value),
        .s_field_width  (s_field_width),
        .s_payload_in   (s_payload_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_value   (m_read_value),
        .m_cursor_bits  (m_cursor_bits),
        .m_free_bits    (m_free_bits),
        .m_length_bytes (m_length_bytes),
        .m_payload_out  (m_payload_out),
        .m_overflow     (m_overflow),
        .mismatches     (mismatch_count),
        .outstanding    (results_pending)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("msb_first_bit_field_packer_unit regression: fail");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [PAYLOAD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] val,
                             input logic [WIDTH_W-1:0] w, input logic [PAYLOAD_W-1:0] pin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_field_value <= val;
        s_field_width <= w;
        s_payload_in  <= pin;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
        op_count[op]++;
    endtask

    // Stop offering and wait until every expected result beat has gone out
    task automatic drain_results();
        s_valid <= 1'b0;
        do
            @(negedge aclk);
        while (results_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [CURSOR_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_writes++;
    endtask

    // Well-formed pass: frame cleared, loaded or rewound, fields packed, rewound, then read back
    task automatic pack_sequence();
        int                 n;
        int                 k;
        int                 pick;
        logic [WIDTH_W-1:0] widths[8];
        pick = $urandom_range(3);
        if (pick < 2) begin
            send_beat(OP_CLEAR, $urandom, WIDTH_W'($urandom), rand64());
        end else if (pick == 2) begin
            send_beat(OP_LOAD, $urandom, WIDTH_W'($urandom), rand64());
            send_beat(OP_REWIND, $urandom, WIDTH_W'($urandom), rand64());
        end else begin
            send_beat(OP_REWIND, $urandom, WIDTH_W'($urandom), rand64());
        end
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
            widths[k] = ($urandom_range(7) == 0) ? WIDTH_W'($urandom_range(13, 32))
                                                 : WIDTH_W'($urandom_range(0, 12));
            send_beat(OP_WRITE, $urandom, widths[k], rand64());
        end
        send_beat(OP_REWIND, $urandom, WIDTH_W'($urandom), rand64());
        for (k = 0; k < n; k++) begin
            if ($urandom_range(5) == 0)
                widths[k] = WIDTH_W'($urandom_range(0, 40));
            send_beat(OP_READ, $urandom, widths[k], rand64());
        end
    endtask

    task automatic noise_beat();
        send_beat(OP_W'($urandom_range(0, OP_LAST)), $urandom,
                  WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1)), rand64());
    endtask

    initial begin : stimulus
        int phase;
        int target;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_operation   = OP_CLEAR;
        s_field_value = '0;
        s_field_width = '0;
        s_payload_in  = '0;
        foreach (op_count[i])
            op_count[i] = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset limit of 64, full and overfull fields, zero and wide widths
        send_beat(OP_CLEAR, '0, '0, '0);
        send_beat(OP_WRITE, 32'hFFFF_FFFF, 6'd32, '0);
        send_beat(OP_WRITE, 32'hFFFF_FFFF, 6'd0, '0);
        send_beat(OP_WRITE, 32'h1234_5678, 6'd63, '0);
        send_beat(OP_WRITE, 32'h0000_0001, 6'd1, '0);
        send_beat(OP_REWIND, '0, '0, '0);
        send_beat(OP_READ, '0, 6'd32, '0);
        send_beat(OP_READ, '0, 6'd40, '0);
        send_beat(OP_READ, '0, 6'd5, '0);
        send_beat(OP_READ, '0, 6'd0, '0);
        send_beat(OP_LOAD, '0, '0, '1);
        send_beat(OP_REWIND, '0, '0, '0);
        send_beat(OP_READ, '0, 6'd30, '0);
        send_beat(OP_READ, '0, 6'd31, '0);
        // write that only partly fits
        send_beat(OP_WRITE, 32'h0000_00A5, 6'd8, '0);
        send_beat(OP_LOAD, '1, '1, '0);
        send_beat(OP_LOAD, '0, '0, 64'hA5C3_0F96_1E2D_7B48);
        // unused operation codes
        send_beat(OP_LOAD + 3'd1, $urandom, WIDTH_W'($urandom), rand64());
        send_beat(OP_LOAD + 3'd2, $urandom, WIDTH_W'($urandom), rand64());
        send_beat(OP_LAST, $urandom, WIDTH_W'($urandom), rand64());
        send_beat(OP_CLEAR, '0, '0, '0);
        // zero limit: nothing fits
        write_limit('0);
        send_beat(OP_WRITE, 32'h0000_000F, 6'd4, '0);
        send_beat(OP_READ, '0, 6'd4, '0);
        // limit beyond the frame acts as the frame size
        write_limit('1);
        send_beat(OP_WRITE, 32'h0000_0000, 6'd32, '0);
        send_beat(OP_WRITE, 32'hFFFF_FFFF, 6'd32, '0);
        send_beat(OP_WRITE, 32'h0000_0001, 6'd1, '0);
        // limit dropped below the cursor
        write_limit(CURSOR_W'(16));
        send_beat(OP_WRITE, 32'h0000_0007, 6'd3, '0);
        send_beat(OP_READ, '0, 6'd2, '0);

        // Random phases, each with its own limit and idling mode
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_limit(CURSOR_W'(64));
                1: write_limit(CURSOR_W'(1));
                2: write_limit('1);
                3: write_limit(CURSOR_W'($urandom_range(2, 63)));
                4: write_limit('0);
                5: write_limit(CURSOR_W'($urandom_range(65, 126)));
                6: write_limit(CURSOR_W'($urandom_range(1, 63)));
                default: write_limit(CURSOR_W'(64));
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            target = beats_sent + 205;
            while (beats_sent < target) begin
                if ($urandom_range(3) == 0)
                    noise_beat();
                else
                    pack_sequence();
            end
        end

        // Long receiver hold-off while the sender keeps offering back to back
        write_limit(CURSOR_W'(64));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge aclk);
        hold_off_cycles = 150;
        @(posedge aclk);
        target = beats_sent + 40;
        while (beats_sent < target)
            pack_sequence();

        drain_results();
        repeat (6) @(posedge aclk);

        $display("covered %0d beats: clear %0d, rewind %0d, write %0d, read %0d, load %0d,",
                 beats_sent, op_count[OP_CLEAR], op_count[OP_REWIND], op_count[OP_WRITE],
                 op_count[OP_READ], op_count[OP_LOAD]);
        $display("unused codes %0d, %0d max_bits writes, %0d mismatches",
                 op_count[5] + op_count[6] + op_count[7], limit_writes, mismatch_count);
        if (mismatch_count == 0 && results_pending == 0)
            $display("msb_first_bit_field_packer_unit regression: pass");
        else
            $display("msb_first_bit_field_packer_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/mbfp_pkg.sv
rtl/mbfp_front.sv
rtl/mbfp_cmd_queue.sv
rtl/mbfp_back.sv
rtl/msb_first_bit_field_packer_unit.sv
rtl/mbfp_checker.sv
tb/mbfp_field_checker.sv
tb/testbench.sv
